// ===== rtl/core/bvp_pkg.sv =====
package bvp_pkg;

    localparam int MvW    = 13;
    localparam int CentiW = 14;
    localparam int OffW   = 12;   // offset into a segment, also the segment's span in hundredths
    localparam int DivW   = 12;   // quotient bits of the interpolation
    localparam int ProdW  = 2 * OffW;
    localparam int NumW   = 21;   // largest numerator is below 2**21
    localparam int StepsPerStage = 3;
    localparam int DivStages     = DivW / StepsPerStage;

    localparam int FixedPoints = 12;
    localparam int Segments    = 12;

    localparam logic [MvW-1:0]    ResetFullMv = MvW'(4200);
    localparam logic [CentiW-1:0] FullCenti   = CentiW'(10000);
    localparam logic [1:0]        RegFullAddr = 2'd0;

    localparam logic [MvW-1:0] PointMv [FixedPoints] = '{
        13'd3000, 13'd3300, 13'd3500, 13'd3600, 13'd3700, 13'd3750,
        13'd3800, 13'd3850, 13'd3900, 13'd3950, 13'd4000, 13'd4100
    };

    localparam logic [CentiW-1:0] PointCenti [Segments+1] = '{
        14'd0,    14'd500,  14'd1200, 14'd2800, 14'd5000, 14'd5800, 14'd6500,
        14'd7200, 14'd7800, 14'd8500, 14'd9000, 14'd9600, 14'd10000
    };

    // One item in flight through the divider.
    typedef struct packed {
        logic [DivW-1:0]   rem;
        logic [DivW-1:0]   num_lo;
        logic [DivW-1:0]   quo;
        logic [DivW-1:0]   div;
        logic [CentiW-1:0] base;
    } t_div_item;

    // Handshake between neighboring pipeline parts.
    typedef struct packed {
        logic valid;
        logic adv;
    } t_link;

endpackage

// ===== rtl/core/bvp_front.sv =====
module bvp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [bvp_pkg::MvW-1:0]    i_voltage_mv,
    input  logic [bvp_pkg::MvW-1:0]    i_full_mv,
    input  logic                       i_adv_next,
    output logic                       o_adv,
    output logic                       o_valid,
    output bvp_pkg::t_div_item         o_item
);
    import bvp_pkg::*;

    // Stage A: segment select.
    logic                r_a_valid;
    logic [OffW-1:0]     r_a_off, n_a_off;
    logic [OffW-1:0]     r_a_dp, n_a_dp;
    logic [DivW-1:0]     r_a_div, n_a_div;
    logic [CentiW-1:0]   r_a_base, n_a_base;
    logic [Segments-2:0] hit;
    logic                a_adv;

    // Stage B: product.
    logic                r_b_valid;
    t_div_item           r_b_item, n_b_item;
    logic [ProdW-1:0]    prod;
    logic                b_adv;

    assign b_adv = !r_b_valid || i_adv_next;
    assign a_adv = !r_a_valid || b_adv;
    assign o_adv = a_adv;

    always_comb begin
        for (int k = 0; k < Segments - 1; k++) begin
            hit[k] = (i_voltage_mv <= PointMv[k+1]);
        end
        // The top segment runs from the last fixed point to the full voltage.
        n_a_off  = OffW'(i_voltage_mv - PointMv[FixedPoints-1]);
        n_a_dp   = OffW'(FullCenti - PointCenti[Segments-1]);
        n_a_div  = DivW'(i_full_mv - PointMv[FixedPoints-1]);
        n_a_base = PointCenti[Segments-1];
        // The lowest segment that reaches the voltage wins.
        for (int k = Segments - 2; k >= 0; k--) begin
            if (hit[k]) begin
                n_a_off  = OffW'(i_voltage_mv - PointMv[k]);
                n_a_dp   = OffW'(PointCenti[k+1] - PointCenti[k]);
                n_a_div  = DivW'(PointMv[k+1] - PointMv[k]);
                n_a_base = PointCenti[k];
            end
        end
        // Clamped items pass through the divider with a zero numerator.
        if (i_voltage_mv <= PointMv[0]) begin
            n_a_off  = '0;
            n_a_dp   = '0;
            n_a_div  = DivW'(1);
            n_a_base = '0;
        end else if (i_voltage_mv >= i_full_mv) begin
            n_a_off  = '0;
            n_a_dp   = '0;
            n_a_div  = DivW'(1);
            n_a_base = FullCenti;
        end
    end

    assign prod = r_a_off * r_a_dp;

    always_comb begin
        n_b_item        = '0;
        n_b_item.rem    = DivW'(prod[NumW-1:DivW]);
        n_b_item.num_lo = prod[DivW-1:0];
        n_b_item.quo    = '0;
        n_b_item.div    = r_a_div;
        n_b_item.base   = r_a_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_adv) begin
                r_a_valid <= i_valid;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a_off  <= n_a_off;
            r_a_dp   <= n_a_dp;
            r_a_div  <= n_a_div;
            r_a_base <= n_a_base;
        end
        if (b_adv) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// ===== rtl/core/bvp_div_stage.sv =====
module bvp_div_stage #(
    parameter int STAGE = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bvp_pkg::t_link     i_up,
    input  bvp_pkg::t_div_item i_item,
    input  logic               i_adv_next,
    output bvp_pkg::t_link     o_down,
    output bvp_pkg::t_div_item o_item
);
    import bvp_pkg::*;

    localparam int TopBit = DivW - 1 - StepsPerStage * STAGE;

    logic            r_valid;
    t_div_item       r_item, n_item;
    logic [DivW:0]   trial;
    logic            adv;

    assign adv = !r_valid || i_adv_next;

    // Restoring division, three quotient bits per stage.
    always_comb begin
        trial  = '0;
        n_item = i_item;
        for (int j = 0; j < StepsPerStage; j++) begin
            trial = {n_item.rem, n_item.num_lo[TopBit - j]};
            if (trial >= {1'b0, n_item.div}) begin
                n_item.rem = DivW'(trial - {1'b0, n_item.div});
                n_item.quo[TopBit - j] = 1'b1;
            end else begin
                n_item.rem = trial[DivW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item <= n_item;
        end
    end

    assign o_down.valid = r_valid;
    assign o_down.adv   = adv;
    assign o_item       = r_item;

endmodule

// ===== rtl/core/battery_voltage_to_percent_core.sv =====
// Converts a cell voltage in millivolts into a state of charge in hundredths
// of a percent by linear interpolation over a fixed 13-point discharge curve
// whose top point is the programmable full voltage (register at byte address
// 0, reset 4200 mV). Results at or below 3000 mV are 0, at or above the full
// voltage 10000, and in between the interpolation quotient is truncated. The
// block takes one item per clock while o_stall is low, and each result passes
// through segment select, product, four divider stages of three quotient bits
// each, and the output register. Stalls back up the pipeline one stage at a
// time, so empty stages keep filling while a result waits.
module battery_voltage_to_percent_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bvp_pkg::MvW-1:0]       i_voltage_mv,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bvp_pkg::CentiW-1:0]    o_percent_centi
);
    import bvp_pkg::*;

    logic [MvW-1:0]    r_full_mv;
    logic              front_adv;
    logic              front_valid;
    t_div_item         front_item;
    t_link             link  [DivStages+1];
    t_div_item         item  [DivStages+1];
    logic              r_out_valid;
    logic [CentiW-1:0] r_out_centi;
    logic              out_adv;

    assign pready = 1'b1;
    assign prdata = (paddr == RegFullAddr) ? {{(32-MvW){1'b0}}, r_full_mv} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_mv <= ResetFullMv;
        end else if (psel && penable && pwrite && pready && paddr == RegFullAddr) begin
            r_full_mv <= pwdata[MvW-1:0];
        end
    end

    bvp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_voltage_mv (i_voltage_mv),
        .i_full_mv    (r_full_mv),
        .i_adv_next   (link[1].adv),
        .o_adv        (front_adv),
        .o_valid      (front_valid),
        .o_item       (front_item)
    );

    assign o_stall       = !front_adv;
    assign link[0].valid = front_valid;
    assign link[0].adv   = front_adv;
    assign item[0]       = front_item;

    for (genvar s = 0; s < DivStages; s++) begin : g_div
        t_link up;
        logic  adv_next;
        assign up.valid = link[s].valid;
        assign up.adv   = link[s].adv;
        assign adv_next = (s == DivStages - 1) ? out_adv : link[s+2 > DivStages ? DivStages : s+2].adv;

        bvp_div_stage #(
            .STAGE (s)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up       (up),
            .i_item     (item[s]),
            .i_adv_next (adv_next),
            .o_down     (link[s+1]),
            .o_item     (item[s+1])
        );
    end

    assign out_adv = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= link[DivStages].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out_centi <= item[DivStages].base + CentiW'(item[DivStages].quo);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_percent_centi = r_out_centi;

endmodule

// ===== dv/tb_battery_voltage_to_percent_core.sv =====
module tb_battery_voltage_to_percent_core;

    import bvp_pkg::*;

    localparam int unsigned WatchdogLimit = 3000;
    localparam int unsigned DrainCycles   = 12;
    localparam int unsigned Knees         = 12;
    localparam int unsigned ProbeCount    = 25;

    // Discharge curve: fixed knees, plus the programmable full point at the top.
    localparam int unsigned KneeMv [Knees] = '{
        3000, 3300, 3500, 3600, 3700, 3750, 3800, 3850, 3900, 3950, 4000, 4100
    };
    localparam int unsigned KneeCenti [Knees+1] = '{
        0, 500, 1200, 2800, 5000, 5800, 6500, 7200, 7800, 8500, 9000, 9600, 10000
    };

    typedef struct packed {
        logic [MvW-1:0]    mv;
        logic              typed;
        logic [CentiW-1:0] centi;
    } t_probe;

    // Rows with typed = 0 are checked against the predictor instead.
    localparam t_probe Probes [ProbeCount] = '{
        '{13'd0,    1'b1, 14'd0},
        '{13'd3000, 1'b1, 14'd0},
        '{13'd3001, 1'b0, 14'd0},
        '{13'd3150, 1'b0, 14'd0},
        '{13'd3300, 1'b1, 14'd500},
        '{13'd3400, 1'b0, 14'd0},
        '{13'd3500, 1'b1, 14'd1200},
        '{13'd3550, 1'b0, 14'd0},
        '{13'd3600, 1'b1, 14'd2800},
        '{13'd3700, 1'b1, 14'd5000},
        '{13'd3725, 1'b0, 14'd0},
        '{13'd3750, 1'b1, 14'd5800},
        '{13'd3800, 1'b1, 14'd6500},
        '{13'd3850, 1'b1, 14'd7200},
        '{13'd3900, 1'b1, 14'd7800},
        '{13'd3950, 1'b1, 14'd8500},
        '{13'd3999, 1'b0, 14'd0},
        '{13'd4000, 1'b1, 14'd9000},
        '{13'd4096, 1'b0, 14'd0},
        '{13'd4100, 1'b1, 14'd9600},
        '{13'd4101, 1'b0, 14'd0},
        '{13'd4150, 1'b0, 14'd0},
        '{13'd4199, 1'b0, 14'd0},
        '{13'd4200, 1'b1, 14'd10000},
        '{13'd8191, 1'b1, 14'd10000}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    logic [MvW-1:0]    i_voltage_mv;
    logic              o_valid;
    logic              i_stall;
    logic [CentiW-1:0] o_percent_centi;

    logic [MvW-1:0]    full_mv_model;
    logic [CentiW-1:0] soc_expected [$];
    logic [CentiW-1:0] soc_want;
    bit                steady;
    int unsigned       n_fail;
    int unsigned       n_checked;
    int unsigned       n_settings;
    int unsigned       quiet_cycles;

    battery_voltage_to_percent_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_voltage_mv    (i_voltage_mv),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_percent_centi (o_percent_centi)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [CentiW-1:0] soc_centi(logic [MvW-1:0] v, logic [MvW-1:0] full);
        int unsigned lo_mv;
        int unsigned hi_mv;
        int unsigned lo_c;
        int unsigned hi_c;
        if (v <= KneeMv[0]) return '0;
        if (v >= full) return FullCenti;
        for (int k = 0; k < Knees; k++) begin
            lo_mv = KneeMv[k];
            hi_mv = (k + 1 < Knees) ? KneeMv[k+1] : full;
            lo_c  = KneeCenti[k];
            hi_c  = KneeCenti[k+1];
            if (v >= lo_mv && v <= hi_mv && hi_mv > lo_mv) begin
                return CentiW'(lo_c + ((v - lo_mv) * (hi_c - lo_c)) / (hi_mv - lo_mv));
            end
        end
        return '0;
    endfunction

    // Most voltages land on the curve or just past its ends; some hug a knee,
    // the rest cover the whole input range.
    function automatic logic [MvW-1:0] pick_voltage(logic [MvW-1:0] full);
        int sel;
        int hi;
        int knee;
        int k;
        sel = $urandom_range(99, 0);
        hi  = int'(full) + 50;
        if (hi > 8191) hi = 8191;
        if (hi < 3050) hi = 3050;
        if (sel < 60) return MvW'($urandom_range(hi, 2950));
        if (sel < 78) begin
            k    = $urandom_range(Knees, 0);
            knee = (k < Knees) ? int'(KneeMv[k]) : int'(full);
            knee = knee + int'($urandom_range(4, 0)) - 2;
            if (knee < 0) knee = 0;
            if (knee > 8191) knee = 8191;
            return MvW'(knee);
        end
        return MvW'($urandom_range(8191, 0));
    endfunction

    task automatic send_voltage(logic [MvW-1:0] v, logic typed, logic [CentiW-1:0] centi);
        while (!steady && $urandom_range(99, 0) < 20) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_voltage_mv <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        soc_expected.push_back(typed ? centi : soc_centi(v, full_mv_model));
        @(negedge i_clk);
    endtask

    task automatic random_voltages(int n);
        for (int i = 0; i < n; i++) begin
            send_voltage(pick_voltage(full_mv_model), 1'b0, '0);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (soc_expected.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_full_voltage(logic [MvW-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RegFullAddr;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        full_mv_model = value;
        n_settings++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_stall <= steady ? 1'b0 : ($urandom_range(99, 0) < 20);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (soc_expected.size() == 0) begin
                $error("percent_centi: unexpected result %0d", o_percent_centi);
                n_fail++;
            end else begin
                soc_want = soc_expected.pop_front();
                if (o_percent_centi !== soc_want) begin
                    $error("percent_centi mismatch: expected %0d, actual %0d",
                           soc_want, o_percent_centi);
                    n_fail++;
                end
                n_checked++;
            end
        end
    end

    // Watchdog: the run is stuck if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("timeout: %0d results still expected", soc_expected.size());
            $display("tb_battery_voltage_to_percent_core: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_voltage_mv  = '0;
        i_stall       = 1'b0;
        steady        = 1'b0;
        n_fail        = 0;
        n_checked     = 0;
        n_settings    = 1;
        quiet_cycles  = 0;
        full_mv_model = ResetFullMv;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < ProbeCount; i++) begin
            send_voltage(Probes[i].mv, Probes[i].typed, Probes[i].centi);
        end
        random_voltages(120);

        set_full_voltage(13'd4101);
        random_voltages(120);

        // A long run with neither side idling, at the widest top segment.
        set_full_voltage(13'd8191);
        steady = 1'b1;
        random_voltages(150);
        steady = 1'b0;

        // Full voltage below its usual range: the fixed knees take over below it, and at 0 every result clamps.
        set_full_voltage(13'd3800);
        random_voltages(80);
        set_full_voltage(13'd4100);
        random_voltages(60);
        set_full_voltage(13'd0);
        random_voltages(40);

        for (int i = 0; i < 3; i++) begin
            set_full_voltage(MvW'($urandom_range(8191, 4101)));
            random_voltages(100);
        end

        drain();
        $display("checked %0d conversions over %0d full-voltage settings, %0d mismatches",
                 n_checked, n_settings, n_fail);
        if (n_fail == 0) begin
            $display("tb_battery_voltage_to_percent_core: PASS");
        end else begin
            $display("tb_battery_voltage_to_percent_core: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bvp_pkg.sv
rtl/core/bvp_front.sv
rtl/core/bvp_div_stage.sv
rtl/core/battery_voltage_to_percent_core.sv
dv/tb_battery_voltage_to_percent_core.sv
